// File: hw/rtl/xsp_pkg.sv
// Package for the xorshift64* generator: types, constants and hash/scramble functions.
`timescale 1ns / 1ps

package xsp_pkg;

	localparam int WORD_W     = 64;
	localparam int HALF_W     = WORD_W / 2;
	localparam int CNT_W      = 3;
	localparam int HASH_STEPS = 7;
	localparam int MUL_STEPS  = 3;
	localparam int OUT_W      = 3 * WORD_W;

	localparam logic [WORD_W-1:0] MULTIPLIER   = 64'h2545_F491_4F6C_DD1D;
	localparam logic [WORD_W-1:0] DEFAULT_SEED = 64'h0139_408D_CBBF_7A44;

	typedef enum logic [1:0] {
		OP_DRAW   = 2'd0,
		OP_RESEED = 2'd1,
		OP_LOAD   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_HCHK,
		ST_MUL,
		ST_FINISH
	} xsp_state_t;

	typedef struct packed {
		logic             accept;
		logic             hash_en;
		logic             mul_en;
		logic [CNT_W-1:0] cnt;
		logic             state_from_work;
		logic             out_load;
	} xsp_cmd_t;

	typedef struct packed {
		logic work_zero;
	} xsp_sts_t;

	// one step of the 64-bit integer hash
	function automatic logic [WORD_W-1:0] wang_step(input logic [WORD_W-1:0] k,
			input logic [CNT_W-1:0] idx);
		logic [WORD_W-1:0] r;
		case (idx)
			3'd0: r = (~k) + (k << 21);
			3'd1: r = k ^ (k >> 24);
			3'd2: r = k + (k << 3) + (k << 8);
			3'd3: r = k ^ (k >> 14);
			3'd4: r = k + (k << 2) + (k << 4);
			3'd5: r = k ^ (k >> 28);
			3'd6: r = k + (k << 31);
			default: r = k;
		endcase
		return r;
	endfunction

	// full hash, used for the reset constant only
	function automatic logic [WORD_W-1:0] wang_mix(input logic [WORD_W-1:0] k);
		logic [WORD_W-1:0] r;
		r = k;
		for (int i = 0; i < HASH_STEPS; i++) begin
			r = wang_step(r, CNT_W'(i));
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] s);
		logic [WORD_W-1:0] r;
		r = s ^ (s >> 12);
		r = r ^ (r << 25);
		r = r ^ (r >> 27);
		return r;
	endfunction

	localparam logic [WORD_W-1:0] RESET_STATE = wang_mix(DEFAULT_SEED);

endpackage

// File: hw/rtl/xsp_ctrl.sv
// Controller state machine: handshakes, hash and multiply sequencing.
`timescale 1ns / 1ps

module xsp_ctrl
	import xsp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  logic [1:0] s_tuser,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  xsp_sts_t sts,
	output xsp_cmd_t cmd
);

	xsp_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic pass_q, pass_d;
	logic m_tvalid_q;
	logic out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			pass_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pass_q  <= pass_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		pass_d   = pass_q;
		cmd      = '0;
		cmd.cnt  = cnt_q;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					cnt_d      = '0;
					pass_d     = 1'b0;
					case (s_tuser)
						OP_DRAW:   state_d = ST_MUL;
						OP_RESEED: state_d = ST_HASH;
						default:   state_d = ST_FINISH;
					endcase
				end
			end
			ST_HASH: begin
				cmd.hash_en = 1'b1;
				if (cnt_q == CNT_W'(HASH_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_HCHK;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_HCHK: begin
				if (sts.work_zero && !pass_q) begin
					pass_d  = 1'b1;
					cnt_d   = '0;
					state_d = ST_HASH;
				end else begin
					cmd.state_from_work = 1'b1;
					state_d             = ST_FINISH;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_FINISH;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("result word loaded over an untaken one");
	a_draw_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == OP_DRAW) |=> (state_q == ST_MUL && cnt_q == '0))
		else $error("draw did not start the multiply");
	a_two_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HCHK && pass_q) |=> state_q == ST_FINISH)
		else $error("more than two hash passes");
	a_hash_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HASH) |-> (cnt_q < CNT_W'(HASH_STEPS)))
		else $error("hash step out of range");
	a_mul_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (cnt_q < CNT_W'(MUL_STEPS)))
		else $error("multiply step out of range");
`endif

endmodule

// File: hw/rtl/xsp_datapath.sv
// Datapath: state and seed registers, hash unit, shared 32x32 multiplier, output word.
`timescale 1ns / 1ps

module xsp_datapath
	import xsp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  xsp_cmd_t          cmd,
	input  logic [1:0]        s_tuser,
	input  logic [WORD_W-1:0] s_tdata,
	output xsp_sts_t          sts,
	output logic [OUT_W-1:0]  m_tdata
);

	logic [WORD_W-1:0] state_q;
	logic [WORD_W-1:0] seed_q;
	logic [WORD_W-1:0] work_q;
	logic [WORD_W-1:0] prod_q;
	logic [1:0]        op_q;
	logic [OUT_W-1:0]  out_q;

	logic [HALF_W-1:0] mul_a, mul_b;
	logic [WORD_W-1:0] mul_p;

	// low 64 bits of state * multiplier from three 32x32 partial products
	assign mul_a = (cmd.cnt == CNT_W'(2)) ? state_q[WORD_W-1:HALF_W] : state_q[HALF_W-1:0];
	assign mul_b = (cmd.cnt == CNT_W'(1)) ? MULTIPLIER[WORD_W-1:HALF_W]
		: MULTIPLIER[HALF_W-1:0];
	assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);

	assign sts.work_zero = (work_q == '0);
	assign m_tdata       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RESET_STATE;
			seed_q  <= DEFAULT_SEED;
		end else begin
			if (cmd.accept) begin
				case (s_tuser)
					OP_DRAW:   state_q <= xorshift(state_q);
					OP_RESEED: seed_q  <= s_tdata;
					OP_LOAD:   state_q <= s_tdata;
					default:   ;
				endcase
			end else if (cmd.state_from_work) begin
				state_q <= work_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= s_tuser;
			work_q <= s_tdata;
		end else if (cmd.hash_en) begin
			work_q <= wang_step(work_q, cmd.cnt);
		end
		if (cmd.mul_en) begin
			if (cmd.cnt == '0) begin
				prod_q <= mul_p;
			end else begin
				prod_q[WORD_W-1:HALF_W] <= prod_q[WORD_W-1:HALF_W] + mul_p[HALF_W-1:0];
			end
		end
		if (cmd.out_load) begin
			out_q <= {seed_q, state_q, (op_q == OP_DRAW) ? prod_q : {WORD_W{1'b0}}};
		end
	end

`ifndef NO_ASSERTIONS
	a_hash_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.state_from_work |=> state_q != '0)
		else $error("reseed left a zero state");
	a_seed_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && s_tuser == OP_RESEED) |=> $stable(seed_q))
		else $error("seed changed without a reseed");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.hash_en && cmd.mul_en) && !(cmd.accept && cmd.out_load))
		else $error("conflicting datapath commands");
`endif

endmodule

// File: hw/rtl/xorshift64star_prng_unit.sv
// Top level of the xorshift64* generator: controller plus datapath.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready; s_tuser is the opcode (0 draw,
//   1 reseed with s_tdata, 2 load s_tdata as raw state, 3 no change) and
//   s_tdata the 64-bit value. Each input word yields exactly one output word
//   on m_tvalid/m_tready, m_tdata = random, state, seed from bit 0 up.
//   Items are handled one at a time; a new word is taken in the idle cycle.
//   From acceptance to the output register the sequencer runs, by opcode:
//     load / no-op : straight to the finish state
//     draw         : three passes through one 32x32 multiplier
//     reseed       : one hash pass, and a second when the first pass yields zero
//                    (one hash step per cycle, seven steps a pass)
//   The result sits in an output register, so the next input word is taken
//   while the previous result still waits; if the receiver stalls, the
//   following item finishes and holds in the controller until the output
//   register frees. Reset loads the default seed and its hash as the state.
`timescale 1ns / 1ps

module xorshift64star_prng_unit
	import xsp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [WORD_W-1:0] s_tdata,   // value
	input  logic [1:0]        s_tuser,   // opcode
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata    // random_value, state_value, seed_value
);

	xsp_cmd_t cmd;
	xsp_sts_t sts;

	xsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	xsp_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.sts     (sts),
		.m_tdata (m_tdata)
	);

endmodule

// File: verif/xsp_checker.sv
// Checker for the xorshift64* generator: predicts each output word and compares it.
`timescale 1ns / 1ps

module xsp_checker
	import xsp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [WORD_W-1:0] s_tdata,   // value
	input  logic [1:0]        s_tuser,   // opcode
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [OUT_W-1:0]  m_tdata,   // random_value, state_value, seed_value
	output int                errors,
	output int                pending
);

	localparam int PRINT_MAX = 50;

	// seed in the top bits, random draw in the low bits, as on m_tdata
	typedef struct packed {
		logic [WORD_W-1:0] seed;
		logic [WORD_W-1:0] state;
		logic [WORD_W-1:0] rnd;
	} out_word_t;

	out_word_t         predicted_q[$];
	logic [WORD_W-1:0] gen_state;
	logic [WORD_W-1:0] seed_reg;

	initial begin
		errors  = 0;
		pending = 0;
	end

	function automatic logic [WORD_W-1:0] hash64(input logic [WORD_W-1:0] k);
		logic [WORD_W-1:0] r;
		r = (k << 21) - k - 64'd1;
		r = r ^ (r >> 24);
		r = r * 64'd265;
		r = r ^ (r >> 14);
		r = r * 64'd21;
		r = r ^ (r >> 28);
		r = r * 64'h0000_0000_8000_0001;
		return r;
	endfunction

	task automatic reseed_with(input logic [WORD_W-1:0] s);
		logic [WORD_W-1:0] h;
		seed_reg = s;
		h = hash64(s);
		if (h == '0) begin
			h = hash64(h);
		end
		gen_state = h;
	endtask

	task automatic advance_generator(input logic [1:0] op, input logic [WORD_W-1:0] val,
			output out_word_t w);
		logic [WORD_W-1:0] s;
		w.rnd = '0;
		case (op)
			OP_DRAW: begin
				s = gen_state;
				s = s ^ (s >> 12);
				s = s ^ (s << 25);
				s = s ^ (s >> 27);
				gen_state = s;
				w.rnd = s * MULTIPLIER;
			end
			OP_RESEED: begin
				reseed_with(val);
			end
			OP_LOAD: begin
				gen_state = val;
			end
			default: begin
			end
		endcase
		w.state = gen_state;
		w.seed  = seed_reg;
	endtask

	task automatic report(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		if (errors < PRINT_MAX) begin
			$display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
		end
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		out_word_t got;
		out_word_t want;
		out_word_t nxt;
		if (!arst_n) begin
			predicted_q.delete();
			reseed_with(DEFAULT_SEED);
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (predicted_q.size() == 0) begin
					report("unexpected word, random_value", got.rnd, '0);
				end else begin
					want = predicted_q.pop_front();
					if (got.rnd !== want.rnd) begin
						report("random_value", got.rnd, want.rnd);
					end
					if (got.state !== want.state) begin
						report("state_value", got.state, want.state);
					end
					if (got.seed !== want.seed) begin
						report("seed_value", got.seed, want.seed);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				advance_generator(s_tuser, s_tdata, nxt);
				predicted_q.push_back(nxt);
			end
			pending = predicted_q.size();
		end
	end

endmodule

// File: verif/xorshift64star_prng_unit_tb.sv
// Testbench top for the xorshift64* generator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module xorshift64star_prng_unit_tb;
	import xsp_pkg::*;

	localparam logic [1:0] OP_NOP      = 2'd3;
	localparam int         RAND_ITEMS  = 1530;
	localparam int         CYCLE_LIMIT = 1000000;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [WORD_W-1:0] s_tdata;   // value
	logic [1:0]        s_tuser;   // opcode
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;   // random_value, state_value, seed_value

	int                errors;
	int                pending;
	int                cycle_count = 0;
	int                burst_left;
	int                stall_left = 0;
	bit                calm = 1'b0;
	logic [WORD_W-1:0] zero_seed;

	xorshift64star_prng_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	xsp_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
	end

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** xorshift64star_prng_unit: FAILED **");
			$finish;
		end
	end

	// receiver: ready between random stall stretches, always ready in calm phases
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 30);
			end
		end
	end

	function automatic logic [WORD_W-1:0] mod_inverse(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] inv;
		inv = x;
		repeat (6) begin
			inv = inv * (64'd2 - inv * x);
		end
		return inv;
	endfunction

	function automatic logic [WORD_W-1:0] undo_shift_xor(input logic [WORD_W-1:0] y,
			input int n);
		logic [WORD_W-1:0] r;
		r = y;
		for (int i = 0; i <= WORD_W / n; i++) begin
			r = y ^ (r >> n);
		end
		return r;
	endfunction

	// inverse of the seed hash, to find the one seed that hashes to zero
	function automatic logic [WORD_W-1:0] unhash64(input logic [WORD_W-1:0] y);
		logic [WORD_W-1:0] k;
		k = y * mod_inverse(64'h0000_0000_8000_0001);
		k = undo_shift_xor(k, 28);
		k = k * mod_inverse(64'd21);
		k = undo_shift_xor(k, 14);
		k = k * mod_inverse(64'd265);
		k = undo_shift_xor(k, 24);
		k = (k + 64'd1) * mod_inverse(64'h0000_0000_001F_FFFF);
		return k;
	endfunction

	function automatic logic [WORD_W-1:0] pick_value();
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return '1;
			2:       return 64'd1 << $urandom_range(0, WORD_W - 1);
			3:       return zero_seed;
			4:       return ~(64'd1 << $urandom_range(0, WORD_W - 1));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [1:0] pick_op();
		int r;
		r = $urandom_range(0, 19);
		if (r < 11) begin
			return OP_DRAW;
		end else if (r < 14) begin
			return OP_RESEED;
		end else if (r < 17) begin
			return OP_LOAD;
		end
		return OP_NOP;
	endfunction

	task automatic drive_item(input logic [1:0] op, input logic [WORD_W-1:0] val);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= val;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = calm ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin : stimulus
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = OP_DRAW;
		arst_n     = 1'b0;
		zero_seed  = unhash64('0);
		burst_left = $urandom_range(1, 24);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset state, all opcodes, extremes, zero hash, zero state
		drive_item(OP_DRAW, '0);
		drive_item(OP_NOP, '1);
		drive_item(OP_DRAW, '1);
		drive_item(OP_LOAD, '0);
		drive_item(OP_DRAW, '0);
		drive_item(OP_DRAW, 64'hA5A5_A5A5_A5A5_A5A5);
		drive_item(OP_LOAD, '1);
		drive_item(OP_DRAW, '0);
		drive_item(OP_LOAD, 64'd1);
		drive_item(OP_DRAW, '0);
		drive_item(OP_LOAD, 64'h8000_0000_0000_0000);
		drive_item(OP_DRAW, '0);
		drive_item(OP_RESEED, '0);
		drive_item(OP_DRAW, '0);
		drive_item(OP_RESEED, '1);
		drive_item(OP_DRAW, '0);
		drive_item(OP_RESEED, zero_seed);
		drive_item(OP_DRAW, '0);
		drive_item(OP_NOP, '0);
		drive_item(OP_RESEED, DEFAULT_SEED);
		drive_item(OP_DRAW, '0);
		drive_item(OP_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
		drive_item(OP_DRAW, 64'h5555_5555_5555_5555);
		drive_item(OP_RESEED, 64'h5555_5555_5555_5555);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 200 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			drive_item(pick_op(), pick_value());
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (24) @(posedge clk);

		if (errors == 0) begin
			$display("** xorshift64star_prng_unit: PASSED **");
		end else begin
			$display("** xorshift64star_prng_unit: FAILED **");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/xsp_pkg.sv
hw/rtl/xsp_ctrl.sv
hw/rtl/xsp_datapath.sv
hw/rtl/xorshift64star_prng_unit.sv
verif/xsp_checker.sv
verif/xorshift64star_prng_unit_tb.sv
